// ===== hw/rtl/itrt_pkg.sv =====
// itrt_pkg: shared types, constants and the control store for integer_to_radix_text.
// Holds the microcode ROM, step codes and character tables. No dependencies.
`default_nettype none

package itrt_pkg;

    localparam int STEP_W = 3;

    localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] ST_CHECK = 3'd1;
    localparam logic [STEP_W-1:0] ST_SIGN  = 3'd2;
    localparam logic [STEP_W-1:0] ST_POW   = 3'd3;
    localparam logic [STEP_W-1:0] ST_DIV   = 3'd4;
    localparam logic [STEP_W-1:0] ST_EMIT  = 3'd5;
    localparam logic [STEP_W-1:0] ST_BAD   = 3'd6;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [3:0] BAD_LAST    = 4'd12;
    localparam logic [2:0] DIG_TOP     = 3'd5;
    localparam logic [6:0] CHAR_MINUS  = 7'h2D;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_SIGN,
        EMIT_DIGIT,
        EMIT_BAD
    } emit_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_FIRE,
        C_RADIX_BAD,
        C_POW_DONE,
        C_BIT_ZERO,
        C_CNT_ZERO,
        C_BAD_LAST
    } cond_t;

    typedef struct packed {
        logic              ready;
        logic              pow_op;
        logic              div_op;
        emit_t             emit;
        cond_t             cond;
        logic [STEP_W-1:0] jump_t;
        logic [STEP_W-1:0] jump_f;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t cw;
        cw = '{ready: 1'b0, pow_op: 1'b0, div_op: 1'b0, emit: EMIT_NONE,
               cond: C_ALWAYS, jump_t: ST_IDLE, jump_f: ST_IDLE};
        case (step)
            ST_IDLE:
            begin
                cw.ready  = 1'b1;
                cw.cond   = C_FIRE;
                cw.jump_t = ST_CHECK;
                cw.jump_f = ST_IDLE;
            end
            ST_CHECK:
            begin
                cw.cond   = C_RADIX_BAD;
                cw.jump_t = ST_BAD;
                cw.jump_f = ST_SIGN;
            end
            ST_SIGN:
            begin
                cw.emit   = EMIT_SIGN;
                cw.jump_t = ST_POW;
            end
            ST_POW:
            begin
                cw.pow_op = 1'b1;
                cw.cond   = C_POW_DONE;
                cw.jump_t = ST_DIV;
                cw.jump_f = ST_POW;
            end
            ST_DIV:
            begin
                cw.div_op = 1'b1;
                cw.cond   = C_BIT_ZERO;
                cw.jump_t = ST_EMIT;
                cw.jump_f = ST_DIV;
            end
            ST_EMIT:
            begin
                cw.emit   = EMIT_DIGIT;
                cw.cond   = C_CNT_ZERO;
                cw.jump_t = ST_IDLE;
                cw.jump_f = ST_DIV;
            end
            ST_BAD:
            begin
                cw.emit   = EMIT_BAD;
                cw.cond   = C_BAD_LAST;
                cw.jump_t = ST_IDLE;
                cw.jump_f = ST_BAD;
            end
            default:
            begin
                cw.jump_t = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] code;
        if (d < 6'd10)
        begin
            code = 7'h30 + {1'b0, d};
        end
        else
        begin
            code = 7'h37 + {1'b0, d};
        end
        return code;
    endfunction

    function automatic logic [6:0] bad_char(input logic [3:0] idx);
        logic [6:0] code;
        case (idx)
            4'd0:    code = 7'h49;
            4'd1:    code = 7'h6E;
            4'd2:    code = 7'h76;
            4'd3:    code = 7'h61;
            4'd4:    code = 7'h6C;
            4'd5:    code = 7'h69;
            4'd6:    code = 7'h64;
            4'd7:    code = 7'h20;
            4'd8:    code = 7'h62;
            4'd9:    code = 7'h61;
            4'd10:   code = 7'h73;
            4'd11:   code = 7'h65;
            default: code = 7'h21;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itrt_ifs.sv =====
// itrt_ifs: valid/ready channel interfaces for the number input and the character output.
// Depends on nothing.
`default_nettype none

interface itrt_number_if #(
    parameter int WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface itrt_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;
    logic       bad_radix;

    modport source (output valid, output char_code, output last_char, output bad_radix,
                    input ready);
    modport sink   (input valid, input char_code, input last_char, input bad_radix,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/itrt_ram.sv =====
// itrt_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module itrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_radix_text.sv =====
// integer_to_radix_text: signed integer to ASCII text in base 2..36, most significant first.
// Microcoded sequencer over itrt_pkg control store; uses itrt_ifs and itrt_ram.
// Per number: setup steps (accept, base check, sign step), then one power-search step per digit
// of the result, then per digit 6 shift-subtract steps plus 1 output step.
// One number at a time; output stalls hold the sequencer. Reset: radix 10, sequencer idle.
`default_nettype none

module integer_to_radix_text #(
    parameter int WORD_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       radix_we,
    input  wire logic [5:0] radix_wdata,
    itrt_number_if.sink     number_ch,
    itrt_char_if.source     char_ch
);

    localparam int CNT_W  = $clog2(WORD_BITS);
    localparam int PROD_W = WORD_BITS + 6;
    localparam int SHF_W  = WORD_BITS + 5;

    logic [5:0]                 radix_reg;
    logic [itrt_pkg::STEP_W-1:0] step_reg, step_next;
    logic [WORD_BITS-1:0]       mag_reg, mag_next;
    logic [WORD_BITS-1:0]       pow_reg, pow_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [2:0]                 bit_reg, bit_next;
    logic [5:0]                 dig_reg, dig_next;
    logic                       neg_reg, neg_next;
    logic [3:0]                 idx_reg, idx_next;
    logic                       out_valid_reg, out_valid_next;
    logic [6:0]                 out_char_reg, out_char_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_bad_reg, out_bad_next;

    itrt_pkg::ucode_t           cw;
    logic                       in_fire;
    logic                       radix_bad;
    logic                       slot_free;
    logic                       emit_active;
    logic                       advance;
    logic                       cond_hit;
    logic [PROD_W-1:0]          prod;
    logic                       pow_done;
    logic [SHF_W-1:0]           shifted;
    logic                       take;
    logic [WORD_BITS-1:0]       pow_rdata;
    logic [CNT_W-1:0]           rd_addr;

    assign cw        = itrt_pkg::ucode_rom(step_reg);
    assign in_fire   = number_ch.valid && number_ch.ready;
    assign radix_bad = (radix_reg < itrt_pkg::RADIX_MIN) || (radix_reg > itrt_pkg::RADIX_MAX);
    assign slot_free = !out_valid_reg || char_ch.ready;
    assign emit_active = (cw.emit == itrt_pkg::EMIT_DIGIT) || (cw.emit == itrt_pkg::EMIT_BAD)
                         || ((cw.emit == itrt_pkg::EMIT_SIGN) && neg_reg);
    assign advance   = !emit_active || slot_free;

    assign prod     = PROD_W'(pow_reg) * PROD_W'(radix_reg);
    assign pow_done = prod > PROD_W'(mag_reg);
    assign shifted  = SHF_W'(pow_reg) << bit_reg;
    assign take     = shifted <= SHF_W'(mag_reg);
    assign rd_addr  = cnt_reg - CNT_W'(1);

    assign number_ch.ready   = cw.ready;
    assign char_ch.valid     = out_valid_reg;
    assign char_ch.char_code = out_char_reg;
    assign char_ch.last_char = out_last_reg;
    assign char_ch.bad_radix = out_bad_reg;

    itrt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_BITS)
    ) u_pow_ram (
        .clk   (clk),
        .we    (cw.pow_op),
        .waddr (cnt_reg),
        .wdata (pow_reg),
        .raddr (rd_addr),
        .rdata (pow_rdata)
    );

    always_comb
    begin
        case (cw.cond)
            itrt_pkg::C_ALWAYS:    cond_hit = 1'b1;
            itrt_pkg::C_FIRE:      cond_hit = in_fire;
            itrt_pkg::C_RADIX_BAD: cond_hit = radix_bad;
            itrt_pkg::C_POW_DONE:  cond_hit = pow_done;
            itrt_pkg::C_BIT_ZERO:  cond_hit = (bit_reg == 3'd0);
            itrt_pkg::C_CNT_ZERO:  cond_hit = (cnt_reg == '0);
            itrt_pkg::C_BAD_LAST:  cond_hit = (idx_reg == itrt_pkg::BAD_LAST);
            default:               cond_hit = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        mag_next       = mag_reg;
        pow_next       = pow_reg;
        cnt_next       = cnt_reg;
        bit_next       = bit_reg;
        dig_next       = dig_reg;
        neg_next       = neg_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !char_ch.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;

        if (advance)
        begin
            step_next = cond_hit ? cw.jump_t : cw.jump_f;
        end

        if (in_fire)
        begin
            neg_next = number_ch.number[WORD_BITS-1];
            mag_next = number_ch.number[WORD_BITS-1] ? (~number_ch.number + WORD_BITS'(1))
                                                     : number_ch.number;
            pow_next = WORD_BITS'(1);
            cnt_next = '0;
            idx_next = '0;
        end

        if (cw.pow_op)
        begin
            bit_next = itrt_pkg::DIG_TOP;
            dig_next = '0;
            if (!pow_done)
            begin
                pow_next = prod[WORD_BITS-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (cw.div_op)
        begin
            bit_next = bit_reg - 3'd1;
            if (take)
            begin
                mag_next = mag_reg - shifted[WORD_BITS-1:0];
                dig_next[bit_reg] = 1'b1;
            end
        end

        if (emit_active && slot_free)
        begin
            out_valid_next = 1'b1;
            case (cw.emit)
                itrt_pkg::EMIT_SIGN:
                begin
                    out_char_next = itrt_pkg::CHAR_MINUS;
                    out_last_next = 1'b0;
                    out_bad_next  = 1'b0;
                end
                itrt_pkg::EMIT_DIGIT:
                begin
                    out_char_next = itrt_pkg::digit_char(dig_reg);
                    out_last_next = (cnt_reg == '0);
                    out_bad_next  = 1'b0;
                    bit_next      = itrt_pkg::DIG_TOP;
                    dig_next      = '0;
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                        pow_next = pow_rdata;
                    end
                end
                itrt_pkg::EMIT_BAD:
                begin
                    out_char_next = itrt_pkg::bad_char(idx_reg);
                    out_last_next = (idx_reg == itrt_pkg::BAD_LAST);
                    out_bad_next  = 1'b1;
                    idx_next      = idx_reg + 4'd1;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !char_ch.ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= itrt_pkg::RADIX_RESET;
            step_reg      <= itrt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (radix_we)
            begin
                radix_reg <= radix_wdata;
            end
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        pow_reg      <= pow_next;
        cnt_reg      <= cnt_next;
        bit_reg      <= bit_next;
        dig_reg      <= dig_next;
        neg_reg      <= neg_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    a_digit_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == itrt_pkg::ST_EMIT) |-> (dig_reg < radix_reg))
        else $error("quotient digit not below radix");

    a_bad_flag_only_bad_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> radix_bad)
        else $error("error text with valid radix");

    a_accept_goes_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (step_reg == itrt_pkg::ST_CHECK))
        else $error("sequencer did not leave idle on transaction");

endmodule

`default_nettype wire
